FILE: src/gsi3_pkg.sv
// ----------------------------------------------------------------------------
// gsi3_pkg
// Shared types and constants for the SI3 field extractor.
// ----------------------------------------------------------------------------
package gsi3_pkg;

    // Results per byte, at most
    localparam int unsigned SLOTS      = 4;
    localparam int unsigned SLOT_W     = 2;
    localparam int unsigned ID_W       = 5;
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned DEC_W      = 11;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [POS_W-1:0] POS_MAX = 5'd31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SI3_TYPE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SI2_TYPE = 1'b1;

    localparam logic [7:0] SI3_TYPE_RST = 8'd27;
    localparam logic [7:0] SI2_TYPE_RST = 8'd26;

    // Field identifiers
    localparam logic [ID_W-1:0] FID_LENGTH      = 5'd0;
    localparam logic [ID_W-1:0] FID_PD          = 5'd1;
    localparam logic [ID_W-1:0] FID_SKIP        = 5'd2;
    localparam logic [ID_W-1:0] FID_TYPE        = 5'd3;
    localparam logic [ID_W-1:0] FID_CELLID      = 5'd4;
    localparam logic [ID_W-1:0] FID_MCC         = 5'd5;
    localparam logic [ID_W-1:0] FID_MNC         = 5'd6;
    localparam logic [ID_W-1:0] FID_LAC         = 5'd7;
    localparam logic [ID_W-1:0] FID_CCHCONF     = 5'd8;
    localparam logic [ID_W-1:0] FID_AG_BLKS     = 5'd9;
    localparam logic [ID_W-1:0] FID_ATT         = 5'd10;
    localparam logic [ID_W-1:0] FID_MSCR        = 5'd11;
    localparam logic [ID_W-1:0] FID_PA_MFRMS    = 5'd12;
    localparam logic [ID_W-1:0] FID_CBQ3        = 5'd13;
    localparam logic [ID_W-1:0] FID_T3212       = 5'd14;
    localparam logic [ID_W-1:0] FID_PWRC        = 5'd15;
    localparam logic [ID_W-1:0] FID_DTX         = 5'd16;
    localparam logic [ID_W-1:0] FID_RLT         = 5'd17;
    localparam logic [ID_W-1:0] FID_TXPWR_MAX   = 5'd18;
    localparam logic [ID_W-1:0] FID_RESEL_HYST  = 5'd19;
    localparam logic [ID_W-1:0] FID_RXLEV_MIN   = 5'd20;
    localparam logic [ID_W-1:0] FID_NECI        = 5'd21;
    localparam logic [ID_W-1:0] FID_ACS         = 5'd22;
    localparam logic [ID_W-1:0] FID_RE          = 5'd23;
    localparam logic [ID_W-1:0] FID_CELL_BAR    = 5'd24;
    localparam logic [ID_W-1:0] FID_TX_INTEGER  = 5'd25;
    localparam logic [ID_W-1:0] FID_MAX_RETRANS = 5'd26;
    localparam logic [ID_W-1:0] FID_RACH_OCT3   = 5'd27;
    localparam logic [ID_W-1:0] FID_RACH_OCT4   = 5'd28;
    localparam logic [ID_W-1:0] FID_REST_OCTETS = 5'd29;
    localparam logic [ID_W-1:0] FID_SI2_RAW     = 5'd30;

    // Message kind, latched at the type byte
    typedef enum logic [3:0] {
        KIND_NONE  = 4'b0001,
        KIND_SI3   = 4'b0010,
        KIND_SI2   = 4'b0100,
        KIND_OTHER = 4'b1000
    } kind_t;

    // All results caused by one byte
    typedef struct packed {
        logic [SLOT_W-1:0]            last_idx;
        logic [SLOTS-1:0][ID_W-1:0]   id;
        logic [SLOTS-1:0][VAL_W-1:0]  val;
    } job_t;

endpackage

FILE: src/gsi3_front.sv
// ----------------------------------------------------------------------------
// gsi3_front
// Byte classifier: reverses each byte, tracks message position and kind,
// and builds the list of results the byte causes.
// ----------------------------------------------------------------------------
module gsi3_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [gsi3_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gsi3_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 take,
    input  logic [7:0]                           msg_byte,
    input  logic                                 last_byte,
    output logic                                 push,
    output gsi3_pkg::job_t                       push_job
);

    logic [7:0]                  si3_type_reg;
    logic [7:0]                  si2_type_reg;
    logic [gsi3_pkg::POS_W-1:0]  pos_reg;
    gsi3_pkg::kind_t             kind_reg,  kind_next;
    logic [gsi3_pkg::VAL_W-1:0]  acc_reg,   acc_next;
    logic [gsi3_pkg::DEC_W-1:0]  dec_reg,   dec_next;

    logic [7:0]                  r;
    logic [3:0]                  lo;
    logic [3:0]                  hi;
    logic [gsi3_pkg::DEC_W-1:0]  dec_pair;   // lo*10 + hi
    logic [gsi3_pkg::DEC_W-1:0]  dec_ext;    // dec*10 + lo
    gsi3_pkg::job_t              job;
    logic                        has;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            r[i] = msg_byte[7-i];
        end
    end

    assign lo       = r[3:0];
    assign hi       = r[7:4];
    assign dec_pair = gsi3_pkg::DEC_W'(lo) * 11'd10 + gsi3_pkg::DEC_W'(hi);
    assign dec_ext  = dec_reg * 11'd10 + gsi3_pkg::DEC_W'(lo);

    always_comb
    begin
        job       = '0;
        has       = 1'b0;
        kind_next = kind_reg;
        acc_next  = acc_reg;
        dec_next  = dec_reg;

        if (pos_reg == 5'd0)
        begin
            has          = 1'b1;
            job.id[0]    = gsi3_pkg::FID_LENGTH;
            job.val[0]   = 32'(r);
        end
        else if (pos_reg == 5'd1)
        begin
            has          = 1'b1;
            job.last_idx = 2'd1;
            job.id[0]    = gsi3_pkg::FID_PD;
            job.val[0]   = 32'(lo);
            job.id[1]    = gsi3_pkg::FID_SKIP;
            job.val[1]   = 32'(hi);
        end
        else if (pos_reg == 5'd2)
        begin
            has          = 1'b1;
            job.id[0]    = gsi3_pkg::FID_TYPE;
            job.val[0]   = 32'(r);
            // SI3 wins when both registers hold the same code
            if (r == si3_type_reg)
                kind_next = gsi3_pkg::KIND_SI3;
            else if (r == si2_type_reg)
                kind_next = gsi3_pkg::KIND_SI2;
            else
                kind_next = gsi3_pkg::KIND_OTHER;
        end
        else if (kind_reg == gsi3_pkg::KIND_SI2)
        begin
            has          = 1'b1;
            job.id[0]    = gsi3_pkg::FID_SI2_RAW;
            job.val[0]   = 32'(r);
        end
        else if (kind_reg == gsi3_pkg::KIND_SI3)
        begin
            case (pos_reg) inside
                5'd3, 5'd8, 5'd19:
                begin
                    acc_next = 32'(r);
                end
                5'd4:
                begin
                    has        = 1'b1;
                    job.id[0]  = gsi3_pkg::FID_CELLID;
                    job.val[0] = {acc_reg[23:0], r};
                end
                5'd5:
                begin
                    dec_next = dec_pair;
                end
                5'd6:
                begin
                    dec_next   = dec_ext;
                    has        = 1'b1;
                    job.id[0]  = gsi3_pkg::FID_MCC;
                    job.val[0] = 32'(dec_ext);
                end
                5'd7:
                begin
                    dec_next   = dec_pair;
                    has        = 1'b1;
                    job.id[0]  = gsi3_pkg::FID_MNC;
                    job.val[0] = 32'(dec_pair);
                end
                5'd9:
                begin
                    has        = 1'b1;
                    job.id[0]  = gsi3_pkg::FID_LAC;
                    job.val[0] = {acc_reg[23:0], r};
                end
                5'd10:
                begin
                    has          = 1'b1;
                    job.last_idx = 2'd3;
                    job.id[0]    = gsi3_pkg::FID_CCHCONF;
                    job.val[0]   = 32'(r[2:0]);
                    job.id[1]    = gsi3_pkg::FID_AG_BLKS;
                    job.val[1]   = 32'(r[5:3]);
                    job.id[2]    = gsi3_pkg::FID_ATT;
                    job.val[2]   = 32'(r[6]);
                    job.id[3]    = gsi3_pkg::FID_MSCR;
                    job.val[3]   = 32'(r[7]);
                end
                5'd11:
                begin
                    has          = 1'b1;
                    job.last_idx = 2'd1;
                    job.id[0]    = gsi3_pkg::FID_PA_MFRMS;
                    job.val[0]   = 32'(r[2:0]);
                    job.id[1]    = gsi3_pkg::FID_CBQ3;
                    job.val[1]   = 32'(r[6:5]);
                end
                5'd12:
                begin
                    has        = 1'b1;
                    job.id[0]  = gsi3_pkg::FID_T3212;
                    job.val[0] = 32'(r);
                end
                5'd13:
                begin
                    has          = 1'b1;
                    job.last_idx = 2'd2;
                    job.id[0]    = gsi3_pkg::FID_PWRC;
                    job.val[0]   = 32'(r[1]);
                    job.id[1]    = gsi3_pkg::FID_DTX;
                    job.val[1]   = 32'(r[3:2]);
                    job.id[2]    = gsi3_pkg::FID_RLT;
                    job.val[2]   = 32'(hi);
                end
                5'd14:
                begin
                    has          = 1'b1;
                    job.last_idx = 2'd1;
                    job.id[0]    = gsi3_pkg::FID_TXPWR_MAX;
                    job.val[0]   = 32'(r[4:0]);
                    job.id[1]    = gsi3_pkg::FID_RESEL_HYST;
                    job.val[1]   = 32'(r[7:5]);
                end
                5'd15:
                begin
                    has          = 1'b1;
                    job.last_idx = 2'd2;
                    job.id[0]    = gsi3_pkg::FID_RXLEV_MIN;
                    job.val[0]   = 32'(r[5:0]);
                    job.id[1]    = gsi3_pkg::FID_NECI;
                    job.val[1]   = 32'(r[6]);
                    job.id[2]    = gsi3_pkg::FID_ACS;
                    job.val[2]   = 32'(r[7]);
                end
                5'd16:
                begin
                    has          = 1'b1;
                    job.last_idx = 2'd3;
                    job.id[0]    = gsi3_pkg::FID_RE;
                    job.val[0]   = 32'(r[0]);
                    job.id[1]    = gsi3_pkg::FID_CELL_BAR;
                    job.val[1]   = 32'(r[1]);
                    job.id[2]    = gsi3_pkg::FID_TX_INTEGER;
                    job.val[2]   = 32'(r[5:2]);
                    job.id[3]    = gsi3_pkg::FID_MAX_RETRANS;
                    job.val[3]   = 32'(r[7:6]);
                end
                5'd17:
                begin
                    has        = 1'b1;
                    job.id[0]  = gsi3_pkg::FID_RACH_OCT3;
                    job.val[0] = 32'(r);
                end
                5'd18:
                begin
                    has        = 1'b1;
                    job.id[0]  = gsi3_pkg::FID_RACH_OCT4;
                    job.val[0] = 32'(r);
                end
                5'd20, 5'd21:
                begin
                    acc_next = {acc_reg[23:0], r};
                end
                5'd22:
                begin
                    has        = 1'b1;
                    job.id[0]  = gsi3_pkg::FID_REST_OCTETS;
                    job.val[0] = {acc_reg[23:0], r};
                end
                default:
                begin
                end
            endcase
        end
    end

    assign push     = take && has;
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            si3_type_reg <= gsi3_pkg::SI3_TYPE_RST;
            si2_type_reg <= gsi3_pkg::SI2_TYPE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == gsi3_pkg::CFG_SI3_TYPE)
                si3_type_reg <= cfg_data;
            if (cfg_index == gsi3_pkg::CFG_SI2_TYPE)
                si2_type_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            kind_reg <= gsi3_pkg::KIND_NONE;
            acc_reg  <= '0;
            dec_reg  <= '0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                pos_reg  <= '0;
                kind_reg <= gsi3_pkg::KIND_NONE;
                acc_reg  <= '0;
                dec_reg  <= '0;
            end
            else
            begin
                if (pos_reg != gsi3_pkg::POS_MAX)
                    pos_reg <= pos_reg + 5'd1;
                kind_reg <= kind_next;
                acc_reg  <= acc_next;
                dec_reg  <= dec_next;
            end
        end
    end

endmodule

FILE: src/gsi3_queue.sv
// ----------------------------------------------------------------------------
// gsi3_queue
// Small FIFO of per-byte result lists between classifier and emitter.
// ----------------------------------------------------------------------------
module gsi3_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gsi3_pkg::job_t   push_job,
    output logic             full,
    input  logic             pop,
    output gsi3_pkg::job_t   pop_job,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    gsi3_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: src/gsi3_back.sv
// ----------------------------------------------------------------------------
// gsi3_back
// Result emitter: holds one byte's result list and sends it one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module gsi3_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             empty,
    input  gsi3_pkg::job_t                   pop_job,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [gsi3_pkg::ID_W-1:0]        field_id,
    output logic [gsi3_pkg::VAL_W-1:0]       field_value,
    output logic                             last_result
);

    gsi3_pkg::job_t               job_reg;
    logic                         busy_reg;
    logic [gsi3_pkg::SLOT_W-1:0]  idx_reg;
    logic                         at_end;
    logic                         done;

    assign at_end      = (idx_reg == job_reg.last_idx);
    assign done        = busy_reg && out_ready && at_end;
    assign pop         = !empty && (!busy_reg || done);

    assign out_valid   = busy_reg;
    assign field_id    = job_reg.id[idx_reg];
    assign field_value = job_reg.val[idx_reg];
    assign last_result = at_end;

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= pop_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (busy_reg && out_ready)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

FILE: src/gsi3_field_extractor_top.sv
// ----------------------------------------------------------------------------
// gsm_si3_field_extractor
// BCCH system information field extractor: header fields, SI3 field
// decoding and SI2 raw byte passthrough.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  -------------------------------
//  in        sink       in_valid / in_ready    msg_byte, last_byte
//  out       source     out_valid / out_ready  field_id, field_value,
//                                              last_result
//  cfg       sink       cfg_we (no wait)       cfg_index, cfg_data
//
//  A byte request is classified in the cycle it is accepted; its results
//  (zero to four) go into a QUEUE_DEPTH-entry queue and are sent one per
//  cycle by the emitter while out_ready is high. The single result port
//  sets the sustained byte rate. Bytes without results never touch the
//  queue. in_ready drops only while the queue is full; output stalls back
//  up into it.
//  Reset clears position, message kind, both accumulators and the queue, and
//  loads the type registers with 27 (SI3) and 26 (SI2).
//
module gsm_si3_field_extractor
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration writes
    input  logic                                 cfg_we,
    input  logic [gsi3_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gsi3_pkg::CFG_DATA_W-1:0]      cfg_data,

    // byte requests
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           msg_byte,
    input  logic                                 last_byte,

    // result requests
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gsi3_pkg::ID_W-1:0]            field_id,
    output logic [gsi3_pkg::VAL_W-1:0]           field_value,
    output logic                                 last_result
);

    logic            take;
    logic            push;
    gsi3_pkg::job_t  push_job;
    logic            q_full;
    logic            q_empty;
    logic            pop;
    gsi3_pkg::job_t  pop_job;

    // Take a byte whenever the queue has room; a byte that yields results
    // always finds a free entry.
    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    gsi3_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .msg_byte  (msg_byte),
        .last_byte (last_byte),
        .push      (push),
        .push_job  (push_job)
    );

    gsi3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    gsi3_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (q_empty),
        .pop_job     (pop_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .field_id    (field_id),
        .field_value (field_value),
        .last_result (last_result)
    );

endmodule

FILE: dv/gsm_si3_field_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm_si3_field_extractor_tb
// Self-checking bench for the BCCH SI3 field extractor. Byte requests are
// decoded by a local predictor as they are accepted; every result request is
// compared field by field against the oldest predicted field. Directed SI3/SI2
// messages come first, then a register change inside a message, type code sweeps,
// a long output stall, a stretch without idling and random traffic.
// ----------------------------------------------------------------------------
module gsm_si3_field_extractor_tb;

    localparam int unsigned ITEM_TARGET    = 470;
    localparam int unsigned HOLD_CYCLES    = 64;   // long output stall
    localparam int unsigned DRAIN_CYCLES   = 8;    // no-result bytes finish within this
    localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles without progress
    localparam int unsigned IDLE_PCT       = 28;

    typedef struct {
        logic [gsi3_pkg::ID_W-1:0]  id;
        logic [gsi3_pkg::VAL_W-1:0] value;
        logic                       last;
    } field_rec_t;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [gsi3_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gsi3_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [7:0]                      msg_byte;
    logic                            last_byte;
    logic                            out_valid;
    logic                            out_ready;
    logic [gsi3_pkg::ID_W-1:0]       field_id;
    logic [gsi3_pkg::VAL_W-1:0]      field_value;
    logic                            last_result;

    gsm_si3_field_extractor DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .msg_byte    (msg_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .field_id    (field_id),
        .field_value (field_value),
        .last_result (last_result)
    );

    // ------------------------------------------------------------------------
    // Clock: 20 ns period
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: own copy of the type codes and the message decode
    // ------------------------------------------------------------------------
    logic [7:0]                 si3_code = gsi3_pkg::SI3_TYPE_RST;
    logic [7:0]                 si2_code = gsi3_pkg::SI2_TYPE_RST;
    logic [gsi3_pkg::POS_W-1:0] byte_pos = '0;
    gsi3_pkg::kind_t            msg_kind = gsi3_pkg::KIND_NONE;
    logic [31:0]                word_acc = '0;   // multi-byte fields
    logic [gsi3_pkg::DEC_W-1:0] digit_acc = '0;  // MCC / MNC decimal build-up

    field_rec_t  pending_fields[$];    // predicted, not yet seen on the output
    field_rec_t  byte_fields[$];       // fields caused by the byte being decoded

    int unsigned bytes_taken = 0;      // accepted byte requests
    int unsigned mismatches  = 0;
    int unsigned stall_count = 0;

    // Side controls for the two traffic processes
    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;

    function automatic logic [7:0] flip8(input logic [7:0] b);
        logic [7:0] f;
        for (int i = 0; i < 8; i++)
            f[i] = b[7-i];
        return f;
    endfunction

    function automatic void emit(input logic [gsi3_pkg::ID_W-1:0] id,
                                 input logic [31:0] value);
        field_rec_t rec;
        rec.id    = id;
        rec.value = value;
        rec.last  = 1'b0;
        byte_fields.push_back(rec);
    endfunction

    // Decode one accepted byte; queues its fields, last one flagged.
    task automatic decode_byte(input logic [7:0] raw, input logic last);
        logic [7:0]  r;
        logic [3:0]  lo;
        logic [3:0]  hi;
        logic [31:0] d;
        field_rec_t  rec;
        r  = flip8(raw);
        lo = r[3:0];
        hi = r[7:4];
        if (byte_pos == 0)
        begin
            emit(gsi3_pkg::FID_LENGTH, 32'(r));
        end
        else if (byte_pos == 1)
        begin
            emit(gsi3_pkg::FID_PD, 32'(lo));
            emit(gsi3_pkg::FID_SKIP, 32'(hi));
        end
        else if (byte_pos == 2)
        begin
            emit(gsi3_pkg::FID_TYPE, 32'(r));
            // SI3 wins when both codes match
            if (r == si3_code)
                msg_kind = gsi3_pkg::KIND_SI3;
            else if (r == si2_code)
                msg_kind = gsi3_pkg::KIND_SI2;
            else
                msg_kind = gsi3_pkg::KIND_OTHER;
        end
        else if (msg_kind == gsi3_pkg::KIND_SI2)
        begin
            emit(gsi3_pkg::FID_SI2_RAW, 32'(r));
        end
        else if (msg_kind == gsi3_pkg::KIND_SI3)
        begin
            case (byte_pos)
                3, 8, 19: word_acc = 32'(r);
                4:  emit(gsi3_pkg::FID_CELLID, (word_acc << 8) | 32'(r));
                5:
                begin
                    d = 32'(lo) * 10 + 32'(hi);
                    digit_acc = d[gsi3_pkg::DEC_W-1:0];
                end
                6:
                begin
                    d = 32'(digit_acc) * 10 + 32'(lo);
                    digit_acc = d[gsi3_pkg::DEC_W-1:0];
                    emit(gsi3_pkg::FID_MCC, 32'(digit_acc));
                end
                7:
                begin
                    d = 32'(lo) * 10 + 32'(hi);
                    digit_acc = d[gsi3_pkg::DEC_W-1:0];
                    emit(gsi3_pkg::FID_MNC, 32'(digit_acc));
                end
                9:  emit(gsi3_pkg::FID_LAC, (word_acc << 8) | 32'(r));
                10:
                begin
                    emit(gsi3_pkg::FID_CCHCONF, 32'(r[2:0]));
                    emit(gsi3_pkg::FID_AG_BLKS, 32'(r[5:3]));
                    emit(gsi3_pkg::FID_ATT, 32'(r[6]));
                    emit(gsi3_pkg::FID_MSCR, 32'(r[7]));
                end
                11:
                begin
                    emit(gsi3_pkg::FID_PA_MFRMS, 32'(r[2:0]));
                    emit(gsi3_pkg::FID_CBQ3, 32'(r[6:5]));
                end
                12: emit(gsi3_pkg::FID_T3212, 32'(r));
                13:
                begin
                    emit(gsi3_pkg::FID_PWRC, 32'(r[1]));
                    emit(gsi3_pkg::FID_DTX, 32'(r[3:2]));
                    emit(gsi3_pkg::FID_RLT, 32'(hi));
                end
                14:
                begin
                    emit(gsi3_pkg::FID_TXPWR_MAX, 32'(r[4:0]));
                    emit(gsi3_pkg::FID_RESEL_HYST, 32'(r[7:5]));
                end
                15:
                begin
                    emit(gsi3_pkg::FID_RXLEV_MIN, 32'(r[5:0]));
                    emit(gsi3_pkg::FID_NECI, 32'(r[6]));
                    emit(gsi3_pkg::FID_ACS, 32'(r[7]));
                end
                16:
                begin
                    emit(gsi3_pkg::FID_RE, 32'(r[0]));
                    emit(gsi3_pkg::FID_CELL_BAR, 32'(r[1]));
                    emit(gsi3_pkg::FID_TX_INTEGER, 32'(r[5:2]));
                    emit(gsi3_pkg::FID_MAX_RETRANS, 32'(r[7:6]));
                end
                17: emit(gsi3_pkg::FID_RACH_OCT3, 32'(r));
                18: emit(gsi3_pkg::FID_RACH_OCT4, 32'(r));
                20, 21: word_acc = (word_acc << 8) | 32'(r);
                22: emit(gsi3_pkg::FID_REST_OCTETS, (word_acc << 8) | 32'(r));
                default: ;  // past the rest octets: nothing
            endcase
        end

        for (int i = 0; i < byte_fields.size(); i++)
        begin
            rec      = byte_fields[i];
            rec.last = (i == byte_fields.size() - 1);
            pending_fields.push_back(rec);
        end
        byte_fields.delete();

        // last byte clears the message; otherwise position saturates
        if (last)
        begin
            byte_pos  = '0;
            msg_kind  = gsi3_pkg::KIND_NONE;
            word_acc  = '0;
            digit_acc = '0;
        end
        else if (byte_pos < gsi3_pkg::POS_MAX)
        begin
            byte_pos = byte_pos + 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: predicts on byte accept, checks each result, runs the watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        field_rec_t exp_rec;
        bit         took_byte;
        bit         took_field;
        if (rst_n)
        begin
            took_byte  = in_valid && in_ready;
            took_field = out_valid && out_ready;

            if (took_byte)
            begin
                decode_byte(msg_byte, last_byte);
                bytes_taken++;
            end

            if (took_field)
            begin
                if (pending_fields.size() == 0)
                begin
                    $display("%0t: unexpected result id %0d value 0x%08h last %0d",
                             $time, field_id, field_value, last_result);
                    mismatches++;
                end
                else
                begin
                    exp_rec = pending_fields.pop_front();
                    if (field_id !== exp_rec.id)
                    begin
                        $display("%0t: field_id expected %0d actual %0d",
                                 $time, exp_rec.id, field_id);
                        mismatches++;
                    end
                    if (field_value !== exp_rec.value)
                    begin
                        $display("%0t: field_value (id %0d) expected 0x%08h actual 0x%08h",
                                 $time, exp_rec.id, exp_rec.value, field_value);
                        mismatches++;
                    end
                    if (last_result !== exp_rec.last)
                    begin
                        $display("%0t: last_result (id %0d) expected %0d actual %0d",
                                 $time, exp_rec.id, exp_rec.last, last_result);
                        mismatches++;
                    end
                end
            end

            // count only cycles where something is owed and nothing moves
            if (took_byte || took_field)
                stall_count = 0;
            else if (in_valid || pending_fields.size() != 0)
                stall_count++;
            if (stall_count >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no progress for %0d cycles", $time, stall_count);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random ready, optional long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Byte request driver. Called at a falling edge; returns at the falling
    // edge after the request was taken, with valid still high.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] raw, input logic last);
        int unsigned taken;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        msg_byte  = raw;
        last_byte = last;
        taken     = bytes_taken;
        do
            @(negedge clk);
        while (bytes_taken == taken);
    endtask

    // Send positions from..to-1 of a message with random content; the type
    // byte carries type_r. ends flags the final byte as last.
    task automatic send_message_part(input logic [7:0] type_r, input int from,
                                     input int to, input bit ends);
        logic [7:0] raw;
        for (int i = from; i < to; i++)
        begin
            raw = (i == 2) ? flip8(type_r) : 8'($urandom_range(255));
            send_byte(raw, ends && (i == to - 1));
        end
    endtask

    // Drop valid, wait until every predicted field has come out, then let
    // result-less bytes settle.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_fields.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write both type codes on back-to-back cycles; block must be idle.
    task automatic write_type_codes(input logic [7:0] si3_val, input logic [7:0] si2_val);
        cfg_we    = 1'b1;
        cfg_index = gsi3_pkg::CFG_SI3_TYPE;
        cfg_data  = si3_val;
        @(negedge clk);
        cfg_index = gsi3_pkg::CFG_SI2_TYPE;
        cfg_data  = si2_val;
        @(negedge clk);
        cfg_we    = 1'b0;
        si3_code  = si3_val;
        si2_code  = si2_val;
    endtask

    task automatic send_random_message();
        int unsigned pick;
        logic [7:0]  t;
        pick = $urandom_range(99);
        if (pick < 45)
            send_message_part(si3_code, 0, 23, 1'b1);                  // full SI3
        else if (pick < 55)
            send_message_part(si3_code, 0, $urandom_range(3, 22), 1'b1); // cut short
        else if (pick < 62)
            send_message_part(si3_code, 0, $urandom_range(24, 36), 1'b1); // overlong
        else if (pick < 77)
            send_message_part(si2_code, 0, $urandom_range(3, 40), 1'b1);
        else if (pick < 87)
        begin
            do
                t = 8'($urandom_range(255));
            while (t == si3_code || t == si2_code);
            send_message_part(t, 0, $urandom_range(3, 8), 1'b1);
        end
        else
        begin
            // header fragments with arbitrary bytes
            send_message_part(8'($urandom_range(255)), 0, $urandom_range(1, 3), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Full SI3 at reset codes with all-ones/all-zeros fields and hex digits.
    task automatic test_si3_directed();
        logic [7:0] r_vals [23];
        r_vals = '{8'hFF, 8'h00, gsi3_pkg::SI3_TYPE_RST, 8'hFF, 8'hFF, 8'hFA, 8'hFF,
                   8'h99, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                   8'hAA, 8'h55, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h01};
        for (int i = 0; i < 23; i++)
            send_byte(flip8(r_vals[i]), i == 22);
    endtask

    // Short SI2 message at reset codes: raw passthrough.
    task automatic test_si2_directed();
        logic [7:0] r_vals [4];
        r_vals = '{8'h00, 8'hFF, gsi3_pkg::SI2_TYPE_RST, 8'hFF};
        for (int i = 0; i < 4; i++)
            send_byte(flip8(r_vals[i]), i == 3);
    endtask

    // Kind is latched at the type byte: changing codes afterwards has no effect.
    task automatic test_mid_message_config();
        logic [7:0] t;
        wait_idle();
        send_message_part(si3_code, 0, 3, 1'b0);
        wait_idle();
        write_type_codes(~si3_code, si3_code);
        send_message_part(8'h00, 3, 23, 1'b1);

        wait_idle();
        do
            t = 8'($urandom_range(255));
        while (t == si3_code || t == si2_code);
        send_message_part(t, 0, 3, 1'b0);
        wait_idle();
        write_type_codes(t, si2_code);
        send_message_part(8'h00, 3, 12, 1'b1);
        wait_idle();
        write_type_codes(gsi3_pkg::SI3_TYPE_RST, gsi3_pkg::SI2_TYPE_RST);
    endtask

    // Code extremes, equal codes, a random pair, then back to reset values.
    task automatic test_type_code_sweep();
        logic [7:0] si3_set [6];
        logic [7:0] si2_set [6];
        si3_set = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, gsi3_pkg::SI3_TYPE_RST};
        si2_set = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, gsi3_pkg::SI2_TYPE_RST};
        si3_set[4] = 8'($urandom_range(255));
        si2_set[4] = 8'($urandom_range(255));
        for (int k = 0; k < 6; k++)
        begin
            wait_idle();
            write_type_codes(si3_set[k], si2_set[k]);
            send_message_part(si3_code, 0, 23, 1'b1);
            send_message_part(si2_code, 0, $urandom_range(4, 12), 1'b1);
        end
    endtask

    // Receiver holds off while bytes keep coming: queue fills, input stalls.
    task automatic test_input_stall();
        wait_idle();
        no_idle  = 1'b1;
        hold_req = 1'b1;
        send_message_part(si3_code, 0, 23, 1'b1);
        wait_idle();
        no_idle  = 1'b0;
    endtask

    // Back-to-back traffic with both sides always ready.
    task automatic test_no_idle_stretch();
        wait_idle();
        no_idle = 1'b1;
        send_message_part(si3_code, 0, 23, 1'b1);
        send_message_part(si2_code, 0, 20, 1'b1);
        send_random_message();
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_random_messages();
        int unsigned count;
        count = 0;
        while (bytes_taken < ITEM_TARGET || count < 6)
        begin
            send_random_message();
            count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = gsi3_pkg::CFG_SI3_TYPE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        msg_byte  = '0;
        last_byte = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_si3_directed();
        test_si2_directed();
        test_mid_message_config();
        test_type_code_sweep();
        test_input_stall();
        test_no_idle_stretch();
        test_random_messages();

        wait_idle();
        if (mismatches == 0 && pending_fields.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: gsm_si3_field_extractor.f
src/gsi3_pkg.sv
src/gsi3_front.sv
src/gsi3_queue.sv
src/gsi3_back.sv
src/gsi3_field_extractor_top.sv
dv/gsm_si3_field_extractor_tb.sv
